// ===== hdl/mvsm_pkg.sv =====
// ============================================================================
// mvsm_pkg - shared definitions for the multi-voice sample mixer
// Sizes, command and status codes, and the control bundle that the
// sequencer hands to the saturating accumulator.
// ============================================================================
package mvsm_pkg;

  // Sizing
  localparam int VOICE_COUNT = 8;
  localparam int CLIP_COUNT  = 2;
  localparam int CLIP_DEPTH  = 16384;

  localparam int VOICE_W   = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int CLIP_W    = (CLIP_COUNT > 1) ? $clog2(CLIP_COUNT) : 1;
  localparam int LEN_W     = $clog2(CLIP_DEPTH + 1);
  localparam int MEM_DEPTH = CLIP_COUNT * CLIP_DEPTH;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  // Fixed field widths
  localparam int CMD_W    = 2;
  localparam int ADDR_W   = 14;
  localparam int SAMPLE_W = 16;
  localparam int STAT_W   = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PLAY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_SAMPLE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_STARTED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_DROPPED = 2'd2;
  localparam logic [STAT_W-1:0] STAT_LOADED  = 2'd3;

  // Accumulator control from the sequencer
  typedef struct packed {
    logic clear;
    logic add;
  } acc_ctl_t;

endpackage

// ===== hdl/multi_voice_sample_mixer_unit.sv =====
// ============================================================================
// multi_voice_sample_mixer_unit - polyphonic clip playback mixer
// Stores clips in a RAM and mixes up to eight voices into one sample per tick.
// ============================================================================
// Usage:
//   A command transaction is taken on a rising edge with start high and busy
//   low. Load (write one clip sample, optionally set the clip length) and
//   play (claim the lowest free voice) finish in the accept cycle; their
//   result strobes on out_valid in the next cycle and busy never rises, so
//   loads and plays can be issued every cycle.
//   A tick raises busy while the sequencer walks the voices in index order:
//   a voice with nothing to read takes the scan state alone; a voice that
//   reads the clip RAM takes the scan state (address) and then the accumulate
//   state (the saturating add on the registered read data); the done state
//   then presents the sum. The single RAM read port and the shared
//   accumulator set how long a tick lasts.
//   Command code 3 is accepted and produces no result.
//   Each result is shown for exactly one cycle; the receiver cannot stall.
//   Reset (synchronous, active low) frees all voices and zeroes clip
//   lengths. The clip RAM is not cleared; samples must be loaded before use.
// ============================================================================
module multi_voice_sample_mixer_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [mvsm_pkg::CMD_W-1:0]           in_command,
  input  logic                                 in_clip_number,
  input  logic [mvsm_pkg::ADDR_W-1:0]          in_sample_address,
  input  logic signed [mvsm_pkg::SAMPLE_W-1:0] in_sample_value,
  input  logic                                 in_final_sample,
  output logic                                 out_valid,
  output logic signed [mvsm_pkg::SAMPLE_W-1:0] out_mixed_sample,
  output logic [mvsm_pkg::STAT_W-1:0]          out_status
);

  localparam int NV  = mvsm_pkg::VOICE_COUNT;
  localparam int NC  = mvsm_pkg::CLIP_COUNT;
  localparam int VW  = mvsm_pkg::VOICE_W;
  localparam int CW  = mvsm_pkg::CLIP_W;
  localparam int LW  = mvsm_pkg::LEN_W;
  localparam int AW  = mvsm_pkg::MEM_AW;
  localparam int SW  = mvsm_pkg::SAMPLE_W;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_ACC  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [VW-1:0] vidx_r, vidx_nxt;

  logic [LW-1:0] clip_size_r   [NC];
  logic [LW-1:0] clip_size_nxt [NC];
  logic [CW-1:0] voice_clip_r  [NV];
  logic [CW-1:0] voice_clip_nxt[NV];
  logic [LW-1:0] voice_pos_r   [NV];
  logic [LW-1:0] voice_pos_nxt [NV];
  logic [NV-1:0] voice_act_r, voice_act_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic signed [SW-1:0] out_mix_r, out_mix_nxt;
  logic [mvsm_pkg::STAT_W-1:0] out_stat_r, out_stat_nxt;

  logic          accept;
  logic          load_ok;
  logic          clip_ok;
  logic [CW-1:0] in_clip;
  logic          free_found;
  logic [VW-1:0] free_idx;

  logic [CW-1:0] cur_clip;
  logic [LW-1:0] cur_len;
  logic [LW-1:0] cur_pos;
  logic [LW-1:0] pos_inc;
  logic          cur_act;
  logic          rd_ok;
  logic          last_voice;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic signed [SW-1:0] mem_rdata;

  mvsm_pkg::acc_ctl_t   acc_ctl;
  logic signed [SW-1:0] acc;

  // Input decode
  assign accept  = start && !busy;
  assign in_clip = CW'(in_clip_number);
  assign clip_ok = (32'(in_clip_number) < NC);
  assign load_ok = clip_ok && (32'(in_sample_address) < mvsm_pkg::CLIP_DEPTH);

  // Lowest-numbered free voice
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NV - 1; i >= 0; i--) begin
      if (!voice_act_r[i]) begin
        free_found = 1'b1;
        free_idx   = VW'(i);
      end
    end
  end

  // Current voice under the sequencer
  assign cur_act    = voice_act_r[vidx_r];
  assign cur_clip   = voice_clip_r[vidx_r];
  assign cur_len    = clip_size_r[cur_clip];
  assign cur_pos    = voice_pos_r[vidx_r];
  assign pos_inc    = cur_pos + LW'(1);
  assign rd_ok      = cur_act && (cur_pos < cur_len) &&
                      (32'(cur_pos) < mvsm_pkg::CLIP_DEPTH);
  assign last_voice = (vidx_r == VW'(NV - 1));

  // Clip RAM ports: writes from loads, reads from the tick scan
  assign mem_we    = accept && (in_command == mvsm_pkg::CMD_LOAD) && load_ok;
  assign mem_waddr = AW'(32'(in_clip_number) * mvsm_pkg::CLIP_DEPTH +
                         32'(in_sample_address));
  assign mem_re    = (state_r == S_SCAN) && rd_ok;
  assign mem_raddr = AW'(32'(cur_clip) * mvsm_pkg::CLIP_DEPTH + 32'(cur_pos));

  mvsm_ram #(
    .WIDTH (SW),
    .DEPTH (mvsm_pkg::MEM_DEPTH)
  ) u_clip_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_sample_value),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Accumulator control
  always_comb begin
    acc_ctl.clear = accept && (in_command == mvsm_pkg::CMD_TICK);
    acc_ctl.add   = (state_r == S_ACC);
  end

  mvsm_sat_acc u_acc (
    .clk    (clk),
    .ctl    (acc_ctl),
    .sample (mem_rdata),
    .acc    (acc)
  );

  // Sequencer and state update
  always_comb begin
    state_nxt      = state_r;
    vidx_nxt       = vidx_r;
    clip_size_nxt  = clip_size_r;
    voice_clip_nxt = voice_clip_r;
    voice_pos_nxt  = voice_pos_r;
    voice_act_nxt  = voice_act_r;
    out_valid_nxt  = 1'b0;
    out_mix_nxt    = '0;
    out_stat_nxt   = out_stat_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_command)
            mvsm_pkg::CMD_LOAD: begin
              if (load_ok && in_final_sample) begin
                clip_size_nxt[in_clip] = LW'(32'(in_sample_address) + 1);
              end
              out_valid_nxt = 1'b1;
              out_stat_nxt  = mvsm_pkg::STAT_LOADED;
            end
            mvsm_pkg::CMD_PLAY: begin
              out_valid_nxt = 1'b1;
              out_stat_nxt  = mvsm_pkg::STAT_DROPPED;
              if (clip_ok && free_found) begin
                voice_clip_nxt[free_idx] = in_clip;
                voice_pos_nxt[free_idx]  = '0;
                voice_act_nxt[free_idx]  = 1'b1;
                out_stat_nxt             = mvsm_pkg::STAT_STARTED;
              end
            end
            mvsm_pkg::CMD_TICK: begin
              vidx_nxt  = '0;
              state_nxt = S_SCAN;
            end
            default: begin
              // unknown command: no state change, no result
            end
          endcase
        end
      end

      // Issue a read, or retire a voice that has nothing to play
      S_SCAN: begin
        if (rd_ok) begin
          state_nxt = S_ACC;
        end else begin
          if (cur_act && (cur_pos >= cur_len)) begin
            voice_act_nxt[vidx_r] = 1'b0;
          end
          if (last_voice) begin
            state_nxt = S_DONE;
          end else begin
            vidx_nxt = vidx_r + VW'(1);
          end
        end
      end

      // Read data is in; the accumulator adds it this cycle
      S_ACC: begin
        voice_pos_nxt[vidx_r] = pos_inc;
        if (pos_inc >= cur_len) begin
          voice_act_nxt[vidx_r] = 1'b0;
        end
        if (last_voice) begin
          state_nxt = S_DONE;
        end else begin
          vidx_nxt  = vidx_r + VW'(1);
          state_nxt = S_SCAN;
        end
      end

      S_DONE: begin
        out_valid_nxt = 1'b1;
        out_mix_nxt   = acc;
        out_stat_nxt  = mvsm_pkg::STAT_SAMPLE;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and voice state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vidx_r      <= '0;
      voice_act_r <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < NC; c++) begin
        clip_size_r[c] <= '0;
      end
      for (int v = 0; v < NV; v++) begin
        voice_clip_r[v] <= '0;
        voice_pos_r[v]  <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      vidx_r       <= vidx_nxt;
      voice_act_r  <= voice_act_nxt;
      out_valid_r  <= out_valid_nxt;
      clip_size_r  <= clip_size_nxt;
      voice_clip_r <= voice_clip_nxt;
      voice_pos_r  <= voice_pos_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_mix_r  <= out_mix_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_mixed_sample = out_mix_r;
  assign out_status       = out_stat_r;

endmodule

// ===== hdl/mvsm_ram.sv =====
// ============================================================================
// mvsm_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ============================================================================
module mvsm_ram #(
  parameter  int WIDTH = 16,
  parameter  int DEPTH = 256,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/mvsm_sat_acc.sv =====
// ============================================================================
// mvsm_sat_acc - saturating mix accumulator
// Adds one sample per step to a 16-bit running sum, clamping to signed range.
// ============================================================================
module mvsm_sat_acc (
  input  logic                                 clk,
  input  mvsm_pkg::acc_ctl_t                   ctl,
  input  logic signed [mvsm_pkg::SAMPLE_W-1:0] sample,
  output logic signed [mvsm_pkg::SAMPLE_W-1:0] acc
);

  localparam int W = mvsm_pkg::SAMPLE_W;

  logic signed [W-1:0] acc_r;
  logic signed [W-1:0] acc_nxt;
  logic signed [W:0]   sum;

  // One guard bit catches overflow; clamp toward the sign of the true sum
  always_comb begin
    sum = {acc_r[W-1], acc_r} + {sample[W-1], sample};
    acc_nxt = acc_r;
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (ctl.add) begin
      if (sum[W] != sum[W-1]) begin
        acc_nxt = sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
        acc_nxt = sum[W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

// ===== hdl/mvsm_checker.sv =====
// ============================================================================
// mvsm_checker - port-level checks for the sample mixer
// Watches command and result transactions at the top-level ports.
// ============================================================================
module mvsm_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 start,
  input logic                                 busy,
  input logic [mvsm_pkg::CMD_W-1:0]           in_command,
  input logic                                 out_valid,
  input logic signed [mvsm_pkg::SAMPLE_W-1:0] out_mixed_sample,
  input logic [mvsm_pkg::STAT_W-1:0]          out_status
);

  // Load answers in the next cycle with a load-done status
  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_command == mvsm_pkg::CMD_LOAD) |=>
      out_valid && (out_status == mvsm_pkg::STAT_LOADED))
    else $error("load transaction without load-done result");

  // Play answers in the next cycle, started or dropped
  a_play_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_command == mvsm_pkg::CMD_PLAY) |=>
      out_valid && ((out_status == mvsm_pkg::STAT_STARTED) ||
                    (out_status == mvsm_pkg::STAT_DROPPED)))
    else $error("play transaction without start/drop result");

  // A tick holds the command port off while voices are mixed
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_command == mvsm_pkg::CMD_TICK) |=> busy && !out_valid)
    else $error("tick did not raise busy");

  // Only a tick result carries a mix value
  a_zero_mix: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != mvsm_pkg::STAT_SAMPLE) |-> (out_mixed_sample == '0))
    else $error("non-tick result with nonzero mix");

  // Nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("result or busy right after reset");

endmodule

bind multi_voice_sample_mixer_unit mvsm_checker u_mvsm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_command       (in_command),
  .out_valid        (out_valid),
  .out_mixed_sample (out_mixed_sample),
  .out_status       (out_status)
);
